// ----- hw/rtl/qtg_pkg.sv -----
// Shared field widths, request codes, register indexes and reset values
// for the Q-value table block. No dependencies.
`default_nettype none

package qtg_pkg;

   // Port field widths
   localparam int REQ_TYPE_W     = 2;
   localparam int STATE_IDX_W    = 8;
   localparam int ACTION_IDX_W   = 3;
   localparam int IO_VALUE_W     = 32;
   localparam int STATUS_W       = 1;
   localparam int STATE_COUNT_W  = 9;
   localparam int ACTION_COUNT_W = 4;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 9;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_GREEDY = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 1'b0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_STATE_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTION_COUNT = 2'd1;

   // Configuration reset values
   localparam logic [STATE_COUNT_W-1:0]  STATE_COUNT_RESET  = 9'd256;
   localparam logic [ACTION_COUNT_W-1:0] ACTION_COUNT_RESET = 4'd8;

   // Result carried from the sequencer to the output register
   typedef struct packed {
      logic signed [IO_VALUE_W-1:0] value;
      logic [ACTION_IDX_W-1:0]      best;
      logic [STATUS_W-1:0]          status;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/qtg_table.sv -----
// Single-port value store with a registered read and a clearing
// pass after reset. Standalone; no package needed.
`default_nettype none

module qtg_table #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   output logic      [WIDTH-1:0]  rd_data,
   output logic                   clear_busy
);

   logic [WIDTH-1:0]  mem [DEPTH];
   logic [WIDTH-1:0]  rd_data_ff;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              clr_busy_ff, clr_busy_in;
   logic              clr_last;

   assign clr_last = (clr_addr_ff == ADDR_W'(DEPTH - 1));

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_last) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // Zero one word a cycle while clearing; otherwise take writes from the port.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/q_table_with_greedy_select.sv -----
// Q-value table with greedy action select: top level, sequencer and output register.
// Depends on qtg_pkg and qtg_table.
`default_nettype none

//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  req     | in        | req_valid/req_stall | req_type, state_index, action_index,
//          |           |                     | write_value
//  rsp     | out       | rsp_valid/rsp_stall | result_value, best_action, status
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
//  Write and error requests finish straight from ST_IDLE; reads go through
//  ST_READ and greedy requests through ST_SCAN, which reads the row over the
//  single table port one word per cycle, up to the effective action count.
//  After reset a clearing pass zeroes all MAX_STATES * MAX_ACTIONS words
//  (2048 by default) one word a cycle; req_stall holds high
//  meanwhile, csr writes are taken throughout.
//  A new request is taken while a finished result still waits in the output
//  register; a second finished result parks in a hold stage until rsp drains.

module q_table_with_greedy_select
   #(
   parameter int MAX_STATES  = 256,
   parameter int MAX_ACTIONS = 8,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,

   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic [qtg_pkg::REQ_TYPE_W-1:0]          req_type,
   input  wire logic [qtg_pkg::STATE_IDX_W-1:0]         req_state_index,
   input  wire logic [qtg_pkg::ACTION_IDX_W-1:0]        req_action_index,
   input  wire logic signed [qtg_pkg::IO_VALUE_W-1:0]   req_write_value,

   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [qtg_pkg::IO_VALUE_W-1:0]        rsp_result_value,
   output logic [qtg_pkg::ACTION_IDX_W-1:0]             rsp_best_action,
   output logic [qtg_pkg::STATUS_W-1:0]                 rsp_status,

   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [qtg_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire logic [qtg_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   import qtg_pkg::*;

   localparam int TABLE_DEPTH = MAX_STATES * MAX_ACTIONS;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int ACT_W       = $clog2(MAX_ACTIONS);
   localparam int NA_W        = ($clog2(MAX_ACTIONS + 1) > ACTION_COUNT_W) ?
                                $clog2(MAX_ACTIONS + 1) : ACTION_COUNT_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_HOLD = 4'b1000
   } seq_state_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [STATE_COUNT_W-1:0]  state_count_ff, state_count_in;
   logic [ACTION_COUNT_W-1:0] action_count_ff, action_count_in;

   assign csr_ready = 1'b1;

   always_comb begin
      state_count_in  = state_count_ff;
      action_count_in = action_count_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STATE_COUNT: begin
               state_count_in = csr_wdata[STATE_COUNT_W-1:0];
            end
            CSR_ACTION_COUNT: begin
               action_count_in = csr_wdata[ACTION_COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_count_ff  <= STATE_COUNT_RESET;
         action_count_ff <= ACTION_COUNT_RESET;
      end else begin
         state_count_ff  <= state_count_in;
         action_count_ff <= action_count_in;
      end
   end

   // Effective action count: register clamped to the table's column count
   logic [NA_W-1:0] na_eff;
   assign na_eff = (NA_W'(action_count_ff) >= NA_W'(MAX_ACTIONS)) ?
                   NA_W'(MAX_ACTIONS) : NA_W'(action_count_ff);

   // ---------------------------------------------------------------------
   // Table
   // ---------------------------------------------------------------------
   logic                   mem_rd_en;
   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_addr;
   logic [VALUE_WIDTH-1:0] mem_wdata;
   logic [VALUE_WIDTH-1:0] mem_rdata;
   logic                   clear_busy;

   qtg_table #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (VALUE_WIDTH)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (mem_rd_en),
      .wr_en      (mem_wr_en),
      .addr       (mem_addr),
      .wr_data    (mem_wdata),
      .rd_data    (mem_rdata),
      .clear_busy (clear_busy)
   );

   // ---------------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------------
   logic              req_xfer;
   logic              state_ok;
   logic              action_ok;
   logic [ADDR_W-1:0] req_base;
   logic [ADDR_W-1:0] req_addr;
   logic [63:0]       wv_wide;

   assign state_ok  = ({1'b0, req_state_index} < state_count_ff) &&
                      (32'(req_state_index) < 32'(MAX_STATES));
   assign action_ok = (ACTION_COUNT_W'(req_action_index) < action_count_ff) &&
                      (32'(req_action_index) < 32'(MAX_ACTIONS));
   assign req_base  = ADDR_W'(req_state_index) * ADDR_W'(MAX_ACTIONS);
   assign req_addr  = req_base + ADDR_W'(req_action_index);
   // Wrap or sign-extend the input value to the stored width
   assign wv_wide   = 64'(req_write_value);

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   seq_state_type                  state_ff, state_in;
   logic [ADDR_W-1:0]              base_ff, base_in;
   logic [ACT_W-1:0]               rcv_ff, rcv_in;
   logic signed [VALUE_WIDTH-1:0]  best_ff, best_in;
   logic [ACT_W-1:0]               best_act_ff, best_act_in;
   result_type                     hold_ff, hold_in;
   result_type                     fin;
   logic                           fin_valid;
   logic                           out_free;
   logic                           scan_last;
   logic                           scan_take;
   logic signed [VALUE_WIDTH-1:0]  rd_signed;
   logic signed [VALUE_WIDTH-1:0]  cand_best;
   logic [ACT_W-1:0]               cand_act;
   logic [63:0]                    rd_wide;
   logic [63:0]                    cand_wide;

   logic                           rsp_valid_ff, rsp_valid_in;
   result_type                     rsp_ff, rsp_in;

   assign req_stall = (state_ff != ST_IDLE) || clear_busy;
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Running maximum: the first word seeds it, later ones replace it only
   // when strictly greater, so ties keep the lower action.
   assign rd_signed = signed'(mem_rdata);
   assign scan_take = (rcv_ff == '0) || (rd_signed > best_ff);
   assign cand_best = scan_take ? rd_signed : best_ff;
   assign cand_act  = scan_take ? rcv_ff : best_act_ff;
   assign scan_last = ((NA_W'(rcv_ff) + NA_W'(1)) == na_eff);
   assign rd_wide   = 64'(rd_signed);
   assign cand_wide = 64'(cand_best);

   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      rcv_in      = rcv_ff;
      best_in     = best_ff;
      best_act_in = best_act_ff;
      hold_in     = hold_ff;
      mem_rd_en   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_addr    = req_addr;
      mem_wdata   = VALUE_WIDTH'(wv_wide);
      fin_valid   = 1'b0;
      fin         = '{value: '0, best: '0, status: STATUS_OK};

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_type)
                  REQ_WRITE: begin
                     fin_valid = 1'b1;
                     if (state_ok && action_ok) begin
                        mem_wr_en = 1'b1;
                     end else begin
                        fin.status = STATUS_RANGE;
                     end
                  end
                  REQ_READ: begin
                     if (state_ok && action_ok) begin
                        mem_rd_en = 1'b1;
                        state_in  = ST_READ;
                     end else begin
                        fin_valid  = 1'b1;
                        fin.status = STATUS_RANGE;
                     end
                  end
                  REQ_GREEDY: begin
                     if (state_ok && (action_count_ff != '0)) begin
                        mem_rd_en = 1'b1;
                        mem_addr  = req_base;
                        base_in   = req_base;
                        rcv_in    = '0;
                        state_in  = ST_SCAN;
                     end else begin
                        fin_valid  = 1'b1;
                        fin.status = STATUS_RANGE;
                     end
                  end
                  default: begin
                     fin_valid  = 1'b1;
                     fin.status = STATUS_RANGE;
                  end
               endcase
            end
         end
         ST_READ: begin
            fin_valid = 1'b1;
            fin.value = IO_VALUE_W'(rd_wide);
            state_in  = ST_IDLE;
         end
         ST_SCAN: begin
            best_in     = cand_best;
            best_act_in = cand_act;
            if (scan_last) begin
               fin_valid = 1'b1;
               fin.value = IO_VALUE_W'(cand_wide);
               fin.best  = ACTION_IDX_W'(cand_act);
               state_in  = ST_IDLE;
            end else begin
               // advance to the next action of the row
               mem_rd_en = 1'b1;
               mem_addr  = base_ff + ADDR_W'(rcv_ff) + ADDR_W'(1);
               rcv_in    = rcv_ff + ACT_W'(1);
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Output register still occupied: park the result
      if (fin_valid && !out_free) begin
         hold_in  = fin;
         state_in = ST_HOLD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      rcv_ff      <= rcv_in;
      best_ff     <= best_in;
      best_act_ff <= best_act_in;
      hold_ff     <= hold_in;
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (fin_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = fin;
      end else if ((state_ff == ST_HOLD) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_ff.value;
   assign rsp_best_action  = rsp_ff.best;
   assign rsp_status       = rsp_ff.status;

`ifndef SYNTHESIS
   // The table is never written while a read or a scan is in flight.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_SCAN) |-> !mem_wr_en)
      else $error("table written during read or scan");

   // A parked result implies the output register is occupied.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("hold stage used with empty output register");

   // The scan index stays inside the effective row.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (NA_W'(rcv_ff) < na_eff))
      else $error("scan index past effective action count");

   // No request starts while the clearing pass runs.
   assert property (@(posedge clock) disable iff (reset)
      clear_busy |=> (state_ff == ST_IDLE))
      else $error("sequencer left idle during clearing pass");
`endif

endmodule

`default_nettype wire

// ----- tb/q_table_with_greedy_select_tb.sv -----
// Self-checking testbench for the Q-value table with greedy action select.
// Depends on qtg_pkg and the q_table_with_greedy_select RTL, which uses qtg_table.
`timescale 1ns / 100ps

module q_table_with_greedy_select_tb;

   import qtg_pkg::*;

   localparam int MAX_STATES    = 256;
   localparam int MAX_ACTIONS   = 8;
   localparam int SETTLE_CYCLES = 16;      // outlasts the longest request
   localparam int LIMIT_CYCLES  = 400000;  // clearing pass plus worst-case run, many times over
   localparam int LONG_HOLD     = 300;
   localparam int N_PLAN        = 35;
   localparam int N_PHASES      = 6;

   // Codes the package leaves unnamed
   localparam logic [REQ_TYPE_W-1:0]  REQ_UNKNOWN = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED  = 2'd3;

   // One row of the directed plan: either a register write or a request,
   // with the expected result typed in when want_typed is set.
   typedef struct packed {
      bit                        is_cfg;
      logic [CSR_INDEX_W-1:0]    reg_index;
      logic [CSR_DATA_W-1:0]     reg_data;
      logic [REQ_TYPE_W-1:0]     kind;
      logic [STATE_IDX_W-1:0]    state_idx;
      logic [ACTION_IDX_W-1:0]   action_idx;
      logic [IO_VALUE_W-1:0]     value;
      bit                        want_typed;
      result_type                want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                          req_valid;
   logic                          req_stall;
   logic [REQ_TYPE_W-1:0]         req_type;
   logic [STATE_IDX_W-1:0]        req_state_index;
   logic [ACTION_IDX_W-1:0]       req_action_index;
   logic signed [IO_VALUE_W-1:0]  req_write_value;

   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [IO_VALUE_W-1:0]  rsp_result_value;
   logic [ACTION_IDX_W-1:0]       rsp_best_action;
   logic [STATUS_W-1:0]           rsp_status;

   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]         csr_wdata;

   // Shadow copy of the table and registers, plus results still owed by the block
   logic signed [IO_VALUE_W-1:0] q_shadow [MAX_STATES*MAX_ACTIONS];
   logic [STATE_COUNT_W-1:0]     states_in_use;
   logic [ACTION_COUNT_W-1:0]    actions_in_use;
   result_type                   owed_results [$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned recv_hold_left;
   int unsigned cycle_count;
   int unsigned mismatch_count;
   int unsigned requests_sent;
   int unsigned greedy_sent;
   int unsigned range_errors;
   int unsigned results_checked;
   int unsigned settings_used;

   plan_row_type directed_plan [N_PLAN];
   int unsigned  phase_states  [N_PHASES] = '{256, 1, 256, 511, 17, 256};
   int unsigned  phase_actions [N_PHASES] = '{8, 8, 5, 15, 1, 8};
   int unsigned  phase_items   [N_PHASES] = '{150, 100, 150, 100, 100, 150};

   q_table_with_greedy_select #(
      .MAX_STATES  (MAX_STATES),
      .MAX_ACTIONS (MAX_ACTIONS),
      .VALUE_WIDTH (32)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_state_index  (req_state_index),
      .req_action_index (req_action_index),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_best_action  (rsp_best_action),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Work out the result of one accepted request and apply its effect
   // on the shadow table. Registers above their bound clamp to the table size.
   function automatic result_type predict_response(input logic [REQ_TYPE_W-1:0] kind,
                                                   input logic [STATE_IDX_W-1:0] state_idx,
                                                   input logic [ACTION_IDX_W-1:0] action_idx,
                                                   input logic [IO_VALUE_W-1:0] value);
      result_type  res;
      int unsigned n_states;
      int unsigned n_actions;
      int unsigned row_base;
      res        = '0;
      res.status = STATUS_OK;
      n_states   = (states_in_use > MAX_STATES) ? MAX_STATES : states_in_use;
      n_actions  = (actions_in_use > MAX_ACTIONS) ? MAX_ACTIONS : actions_in_use;
      row_base   = state_idx * MAX_ACTIONS;
      case (kind)
         REQ_WRITE, REQ_READ: begin
            if (state_idx >= n_states || action_idx >= n_actions) begin
               res.status = STATUS_RANGE;
            end else if (kind == REQ_WRITE) begin
               q_shadow[row_base + action_idx] = value;
            end else begin
               res.value = q_shadow[row_base + action_idx];
            end
         end
         REQ_GREEDY: begin
            if (state_idx >= n_states || n_actions == 0) begin
               res.status = STATUS_RANGE;
            end else begin
               // strict compare keeps the lowest index on ties
               res.value = q_shadow[row_base];
               for (int a = 1; a < n_actions; a++) begin
                  if ($signed(q_shadow[row_base + a]) > $signed(res.value)) begin
                     res.value = q_shadow[row_base + a];
                     res.best  = a[ACTION_IDX_W-1:0];
                  end
               end
            end
         end
         default: begin
            res.status = STATUS_RANGE;
         end
      endcase
      return res;
   endfunction

   function automatic plan_row_type cfg_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type row;
      row           = '0;
      row.is_cfg    = 1'b1;
      row.reg_index = idx;
      row.reg_data  = data;
      return row;
   endfunction

   function automatic plan_row_type req_row(input logic [REQ_TYPE_W-1:0] kind,
                                            input logic [STATE_IDX_W-1:0] state_idx,
                                            input logic [ACTION_IDX_W-1:0] action_idx,
                                            input logic [IO_VALUE_W-1:0] value);
      plan_row_type row;
      row            = '0;
      row.kind       = kind;
      row.state_idx  = state_idx;
      row.action_idx = action_idx;
      row.value      = value;
      return row;
   endfunction

   function automatic plan_row_type chk_row(input logic [REQ_TYPE_W-1:0] kind,
                                            input logic [STATE_IDX_W-1:0] state_idx,
                                            input logic [ACTION_IDX_W-1:0] action_idx,
                                            input logic [IO_VALUE_W-1:0] value,
                                            input logic [IO_VALUE_W-1:0] want_value,
                                            input logic [ACTION_IDX_W-1:0] want_best,
                                            input logic [STATUS_W-1:0] want_status);
      plan_row_type row;
      row             = req_row(kind, state_idx, action_idx, value);
      row.want_typed  = 1'b1;
      row.want.value  = want_value;
      row.want.best   = want_best;
      row.want.status = want_status;
      return row;
   endfunction

   // Offer one request, hold it until the block takes it, then log what it owes.
   // Valid is left high so back-to-back requests keep the channel busy.
   task automatic issue_request(input logic [REQ_TYPE_W-1:0] kind,
                                input logic [STATE_IDX_W-1:0] state_idx,
                                input logic [ACTION_IDX_W-1:0] action_idx,
                                input logic [IO_VALUE_W-1:0] value,
                                input bit want_typed,
                                input result_type want);
      result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_state_index  <= state_idx;
      req_action_index <= action_idx;
      req_write_value  <= value;
      do @(posedge clock); while (req_stall);
      predicted = predict_response(kind, state_idx, action_idx, value);
      owed_results.push_back(want_typed ? want : predicted);
      requests_sent++;
      if (kind == REQ_GREEDY) greedy_sent++;
      if (predicted.status == STATUS_RANGE) range_errors++;
   endtask

   // Drop valid, wait for every owed result, then let the block go quiet.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes only happen with the block idle.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_STATE_COUNT) begin
         states_in_use = data;
      end else if (idx == CSR_ACTION_COUNT) begin
         actions_in_use = data[ACTION_COUNT_W-1:0];
      end
      settings_used++;
   endtask

   // Random request biased toward a few hot rows, so greedy scans see
   // earlier writes and ties; a slice of requests goes out of range or
   // carries the unused code.
   task automatic issue_random_request();
      int unsigned             pick;
      int unsigned             n_states;
      int unsigned             n_actions;
      logic [REQ_TYPE_W-1:0]   kind;
      logic [STATE_IDX_W-1:0]  state_idx;
      logic [ACTION_IDX_W-1:0] action_idx;
      logic [IO_VALUE_W-1:0]   value;
      n_states  = (states_in_use > MAX_STATES) ? MAX_STATES : states_in_use;
      n_actions = (actions_in_use > MAX_ACTIONS) ? MAX_ACTIONS : actions_in_use;

      pick = $urandom_range(99);
      if (pick < 35)      kind = REQ_WRITE;
      else if (pick < 65) kind = REQ_READ;
      else if (pick < 95) kind = REQ_GREEDY;
      else                kind = REQ_UNKNOWN;

      pick = $urandom_range(99);
      if (n_states == 0 || pick >= 85)
         state_idx = STATE_IDX_W'($urandom_range(MAX_STATES-1));
      else if (pick < 70)
         state_idx = STATE_IDX_W'($urandom_range(((n_states < 8) ? n_states : 8) - 1));
      else
         state_idx = STATE_IDX_W'($urandom_range(n_states-1));

      if (n_actions != 0 && $urandom_range(99) < 85)
         action_idx = ACTION_IDX_W'($urandom_range(n_actions-1));
      else
         action_idx = ACTION_IDX_W'($urandom_range(MAX_ACTIONS-1));

      // a small pool of values makes equal maxima common
      case ($urandom_range(9))
         0:       value = 32'h0000_0000;
         1:       value = 32'h7FFF_FFFF;
         2:       value = 32'h8000_0000;
         3:       value = 32'hFFFF_0000;
         4:       value = 32'h0001_0000;
         default: value = $urandom;
      endcase
      issue_request(kind, state_idx, action_idx, value, 1'b0, '0);
   endtask

   // Result side: stall at random, or for a long stretch when armed, and
   // check every transfer against the oldest owed result.
   initial begin
      rsp_stall      = 1'b0;
      recv_hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               $error("unexpected result: value %h best %0d status %0d",
                      rsp_result_value, rsp_best_action, rsp_status);
               mismatch_count++;
            end else begin
               result_type want;
               want = owed_results.pop_front();
               results_checked++;
               if (rsp_result_value !== want.value) begin
                  $error("result_value: expected %h, got %h", want.value, rsp_result_value);
                  mismatch_count++;
               end
               if (rsp_best_action !== want.best) begin
                  $error("best_action: expected %0d, got %0d", want.best, rsp_best_action);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         if (recv_hold_left > 0) begin
            rsp_stall <= 1'b1;
            recv_hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Main sequence: reset, directed plan, then randomized phases over
   // several register settings and three idling profiles.
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_WRITE;
      req_state_index  = '0;
      req_action_index = '0;
      req_write_value  = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_STATE_COUNT;
      csr_wdata        = '0;
      mismatch_count   = 0;
      requests_sent    = 0;
      greedy_sent      = 0;
      range_errors     = 0;
      results_checked  = 0;
      settings_used    = 0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      states_in_use    = STATE_COUNT_RESET;
      actions_in_use   = ACTION_COUNT_RESET;
      foreach (q_shadow[i]) q_shadow[i] = '0;

      // table is all zero after reset: reads and greedy scans see zeros,
      // an all-equal row gives action 0
      directed_plan[0]  = chk_row(REQ_READ,    0,   0, 32'h0, 32'h0, 0, STATUS_OK);
      directed_plan[1]  = chk_row(REQ_GREEDY,  255, 0, 32'h0, 32'h0, 0, STATUS_OK);
      // value extremes, including the most negative in the last action
      directed_plan[2]  = chk_row(REQ_WRITE,   0,   0, 32'h7FFF_FFFF, 32'h0, 0, STATUS_OK);
      directed_plan[3]  = chk_row(REQ_WRITE,   0,   7, 32'h8000_0000, 32'h0, 0, STATUS_OK);
      directed_plan[4]  = chk_row(REQ_WRITE,   0,   3, 32'h7FFF_FFFF, 32'h0, 0, STATUS_OK);
      directed_plan[5]  = chk_row(REQ_READ,    0,   7, 32'h0, 32'h8000_0000, 0, STATUS_OK);
      directed_plan[6]  = chk_row(REQ_GREEDY,  0,   0, 32'h0, 32'h7FFF_FFFF, 0, STATUS_OK);
      // tie between actions 6 and 7: lower index wins
      directed_plan[7]  = chk_row(REQ_WRITE,   255, 6, 32'h7FFF_FFFF, 32'h0, 0, STATUS_OK);
      directed_plan[8]  = chk_row(REQ_WRITE,   255, 7, 32'h7FFF_FFFF, 32'h0, 0, STATUS_OK);
      directed_plan[9]  = chk_row(REQ_GREEDY,  255, 7, 32'h0, 32'h7FFF_FFFF, 6, STATUS_OK);
      // unknown request code: error, and the table stays as it was
      directed_plan[10] = chk_row(REQ_UNKNOWN, 255, 7, 32'hFFFF_FFFF, 32'h0, 0, STATUS_RANGE);
      directed_plan[11] = chk_row(REQ_READ,    255, 7, 32'h0, 32'h7FFF_FFFF, 0, STATUS_OK);
      // small signed fractions in row 1
      directed_plan[12] = req_row(REQ_WRITE,   1,   1, 32'hFFFF_8000);
      directed_plan[13] = req_row(REQ_WRITE,   1,   2, 32'h0000_8000);
      directed_plan[14] = req_row(REQ_GREEDY,  1,   0, 32'h0);
      // narrow table: indexes past the counts are out of range
      directed_plan[15] = cfg_row(CSR_STATE_COUNT,  9'd2);
      directed_plan[16] = cfg_row(CSR_ACTION_COUNT, 9'd3);
      directed_plan[17] = chk_row(REQ_READ,    2,   0, 32'h0, 32'h0, 0, STATUS_RANGE);
      directed_plan[18] = chk_row(REQ_WRITE,   1,   3, 32'h0000_1234, 32'h0, 0, STATUS_RANGE);
      directed_plan[19] = req_row(REQ_GREEDY,  1,   5, 32'h0);
      // counts above their bound clamp to the full table
      directed_plan[20] = cfg_row(CSR_STATE_COUNT,  9'd511);
      directed_plan[21] = cfg_row(CSR_ACTION_COUNT, 9'd15);
      directed_plan[22] = chk_row(REQ_READ,    255, 7, 32'h0, 32'h7FFF_FFFF, 0, STATUS_OK);
      directed_plan[23] = req_row(REQ_GREEDY,  0,   0, 32'h0);
      // zero counts: nothing is in range
      directed_plan[24] = cfg_row(CSR_STATE_COUNT,  9'd0);
      directed_plan[25] = cfg_row(CSR_ACTION_COUNT, 9'd0);
      directed_plan[26] = chk_row(REQ_READ,    0,   0, 32'h0, 32'h0, 0, STATUS_RANGE);
      directed_plan[27] = chk_row(REQ_GREEDY,  0,   0, 32'h0, 32'h0, 0, STATUS_RANGE);
      directed_plan[28] = chk_row(REQ_WRITE,   0,   0, 32'h5, 32'h0, 0, STATUS_RANGE);
      directed_plan[29] = cfg_row(CSR_STATE_COUNT,  9'd256);
      directed_plan[30] = chk_row(REQ_GREEDY,  0,   0, 32'h0, 32'h0, 0, STATUS_RANGE);
      // write to an unused register index, then restore and confirm that
      // the failed writes left the table alone
      directed_plan[31] = cfg_row(CSR_UNUSED,       9'h1FF);
      directed_plan[32] = cfg_row(CSR_ACTION_COUNT, 9'd8);
      directed_plan[33] = chk_row(REQ_READ,    0,   0, 32'h0, 32'h7FFF_FFFF, 0, STATUS_OK);
      directed_plan[34] = chk_row(REQ_READ,    1,   3, 32'h0, 32'h0, 0, STATUS_OK);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part; the first requests wait out the clearing pass behind req_stall.
      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_cfg) begin
            write_register(directed_plan[i].reg_index, directed_plan[i].reg_data);
         end else begin
            issue_request(directed_plan[i].kind, directed_plan[i].state_idx,
                          directed_plan[i].action_idx, directed_plan[i].value,
                          directed_plan[i].want_typed, directed_plan[i].want);
         end
      end

      // Random part: two phases per idling profile.
      for (int p = 0; p < N_PHASES; p++) begin
         write_register(CSR_STATE_COUNT,  CSR_DATA_W'(phase_states[p]));
         write_register(CSR_ACTION_COUNT, CSR_DATA_W'(phase_actions[p]));
         case (p / 2)
            0:       begin send_idle_pct = 27; recv_idle_pct = 73; end
            1:       begin send_idle_pct = 73; recv_idle_pct = 27; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         // hold the result side off while requests keep coming, so the
         // output stages fill and the block stalls its input
         if (p == 2) recv_hold_left = LONG_HOLD;
         for (int n = 0; n < phase_items[p]; n++) begin
            // pause the request side mid-phase until everything has come back
            if (p == N_PHASES-1 && n == phase_items[p] / 2) drain_results();
            issue_random_request();
         end
      end

      drain_results();
      if (owed_results.size() != 0) begin
         $error("%0d expected results never arrived", owed_results.size());
         mismatch_count++;
      end

      $display("Covered %0d requests (%0d greedy, %0d out of range or unknown) over %0d",
               requests_sent, greedy_sent, range_errors, settings_used);
      $display("register writes; %0d results checked in %0d cycles.",
               results_checked, cycle_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
